/* hdl/crc8fpf_pkg.sv */
// Package: sizes, codes and the CRC-8 step shared by the frame receiver.
`default_nettype none
package crc8fpf_pkg;
    localparam int RING_ENTRIES   = 4;
    localparam int FRAME_CAPACITY = 68;
    localparam int SLOT_W         = $clog2(RING_ENTRIES);
    localparam int STORE_DEPTH    = RING_ENTRIES * FRAME_CAPACITY;
    localparam int ADDR_W         = $clog2(STORE_DEPTH);
    localparam int FILL_W         = 7;

    localparam logic [1:0] ENTRY_EMPTY   = 2'd0;
    localparam logic [1:0] ENTRY_FILLING = 2'd1;
    localparam logic [1:0] ENTRY_FULL    = 2'd2;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_EMPTY    = 3'd1;
    localparam logic [2:0] STAT_SIZE     = 3'd2;
    localparam logic [2:0] STAT_START    = 3'd3;
    localparam logic [2:0] STAT_LENGTH   = 3'd4;
    localparam logic [2:0] STAT_CRC      = 3'd5;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_POP  = 2'd2;

    localparam logic [7:0] START_MARK  = 8'h5A;
    localparam logic [7:0] CRC_INIT    = 8'h55;
    localparam logic [7:0] CRC_POLY    = 8'hCF;
    localparam logic [6:0] MAX_PAYLOAD = 7'd64;
    localparam logic [31:0] TIMEOUT_RESET = 32'd10000;

    // Remainder of c * x^8 modulo the polynomial, MSB first.
    function automatic logic [7:0] crc_shift(input logic [7:0] c);
        logic [7:0] t;
        t = c;
        for (int i = 0; i < 8; i++)
        begin
            t = t[7] ? ({t[6:0], 1'b0} ^ CRC_POLY) : {t[6:0], 1'b0};
        end
        return t;
    endfunction
endpackage
`default_nettype wire

/* hdl/crc8fpf_if.sv */
// Interfaces: request channel and response channel.
`default_nettype none
interface crc8fpf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] rx_byte;
    modport source (output valid, kind, rx_byte, input ready);
    modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface crc8fpf_rsp_if;
    logic       valid;
    logic       ready;
    logic       reply_kind;
    logic       accepted;
    logic [2:0] status;
    logic [8:0] command;
    logic [6:0] payload_size;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last;
    modport source (output valid, reply_kind, accepted, status, command, payload_size,
                    data_byte, data_valid, last, input ready);
    modport sink   (input valid, reply_kind, accepted, status, command, payload_size,
                    data_byte, data_valid, last, output ready);
endinterface
`default_nettype wire

/* hdl/crc8fpf_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module crc8fpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

/* hdl/crc8_framed_packet_fifo.sv */
// Framed packet receiver: a ring of frame buffers with CRC-8 checking on pop.
//
// Requests are taken one per cycle while no pop is streaming and the response
// register is free or being taken. A byte request or a pop that yields a single
// report gives its response in the cycle after acceptance; a tick gives none. An ok
// pop streams its N payload bytes: S_READ reads each from the frame store and
// S_SEND sends the read data once the response register is free; the request
// side is held until the last byte is sent. Per-buffer status, fill count, CRC
// and header bytes live in flip-flops; the payload lives in the RAM.
`default_nettype none
module crc8_framed_packet_fifo (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    crc8fpf_req_if.sink      req,
    crc8fpf_rsp_if.source    rsp
);
    localparam int RING = crc8fpf_pkg::RING_ENTRIES;
    localparam int CAP  = crc8fpf_pkg::FRAME_CAPACITY;
    localparam int SW   = crc8fpf_pkg::SLOT_W;
    localparam int AW   = crc8fpf_pkg::ADDR_W;
    localparam int FW   = crc8fpf_pkg::FILL_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SEND = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  status_reg [RING];
    logic [1:0]  status_next [RING];
    logic [FW-1:0] fill_reg [RING];
    logic [FW-1:0] fill_next [RING];
    logic [7:0]  crc_reg [RING];
    logic [7:0]  crc_next [RING];
    logic [31:0] start_reg [RING];
    logic [31:0] start_next [RING];
    logic [7:0]  byte0_reg [RING];
    logic [7:0]  byte0_next [RING];
    logic [7:0]  size_reg [RING];
    logic [7:0]  size_next [RING];
    logic [7:0]  cmd_reg [RING];
    logic [7:0]  cmd_next [RING];
    logic [SW-1:0] wslot_reg, wslot_next, rslot_reg, rslot_next;
    logic [31:0] time_reg, time_next, timeout_reg;

    logic [AW-1:0] base_reg, base_next;
    logic [6:0]  idx_reg, idx_next, ssize_reg, ssize_next;
    logic [8:0]  scmd_reg, scmd_next;

    logic        ov_reg, ov_next, o_rk_reg, o_rk_next, o_acc_reg, o_acc_next;
    logic [2:0]  o_st_reg, o_st_next;
    logic [8:0]  o_cmd_reg, o_cmd_next;
    logic [6:0]  o_sz_reg, o_sz_next;
    logic [7:0]  o_db_reg, o_db_next;
    logic        o_dv_reg, o_dv_next, o_last_reg, o_last_next;

    logic        out_free, req_acc;
    logic        ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_rdata;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == SW'(RING - 1)) ? '0 : s + SW'(1);
    endfunction

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_acc   = req.valid && req.ready;

    always_comb
    begin
        logic [SW-1:0] h1, h2, nx, s;
        logic          h1_ok, h2_ok;
        logic [1:0]    st_eff [RING];
        logic [FW-1:0] f;
        logic [7:0]    szb, cl;
        logic [6:0]    sz;
        logic [2:0]    st;

        state_next = state_reg;
        status_next = status_reg;
        fill_next = fill_reg;
        crc_next = crc_reg;
        start_next = start_reg;
        byte0_next = byte0_reg;
        size_next = size_reg;
        cmd_next = cmd_reg;
        wslot_next = wslot_reg;
        rslot_next = rslot_reg;
        time_next = time_reg;
        base_next = base_reg;
        idx_next = idx_reg;
        ssize_next = ssize_reg;
        scmd_next = scmd_reg;
        ov_next = ov_reg && !rsp.ready;
        o_rk_next = o_rk_reg;
        o_acc_next = o_acc_reg;
        o_st_next = o_st_reg;
        o_cmd_next = o_cmd_reg;
        o_sz_next = o_sz_reg;
        o_db_next = o_db_reg;
        o_dv_next = o_dv_reg;
        o_last_next = o_last_reg;
        ram_we = 1'b0;
        ram_waddr = '0;
        ram_re = 1'b0;
        ram_raddr = base_reg + AW'(idx_reg);
        h1 = '0; h2 = '0; nx = '0; s = '0;
        h1_ok = 1'b0; h2_ok = 1'b0;
        st_eff = status_reg;
        f = '0; szb = '0; cl = '0; sz = '0; st = crc8fpf_pkg::STAT_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    case (req.kind)
                        crc8fpf_pkg::KIND_TICK:
                        begin
                            time_next = time_reg + 32'd1;
                        end
                        crc8fpf_pkg::KIND_BYTE:
                        begin
                            // find the buffer taking bytes
                            nx = next_slot(wslot_reg);
                            if (status_reg[wslot_reg] != crc8fpf_pkg::ENTRY_FULL)
                            begin
                                h1 = wslot_reg; h1_ok = 1'b1;
                            end
                            else if (status_reg[nx] == crc8fpf_pkg::ENTRY_EMPTY)
                            begin
                                h1 = nx; h1_ok = 1'b1;
                            end
                            else
                            begin
                                h1 = wslot_reg;
                            end
                            // force a stale filling buffer full
                            if (h1_ok && status_reg[h1] == crc8fpf_pkg::ENTRY_FILLING &&
                                (time_reg - start_reg[h1]) > timeout_reg)
                            begin
                                st_eff[h1] = crc8fpf_pkg::ENTRY_FULL;
                            end
                            nx = next_slot(h1);
                            if (st_eff[h1] != crc8fpf_pkg::ENTRY_FULL)
                            begin
                                h2 = h1; h2_ok = 1'b1;
                            end
                            else if (st_eff[nx] == crc8fpf_pkg::ENTRY_EMPTY)
                            begin
                                h2 = nx; h2_ok = 1'b1;
                            end
                            else
                            begin
                                h2 = h1;
                            end
                            wslot_next = h2;
                            status_next = st_eff;
                            ov_next = 1'b1;
                            o_rk_next = 1'b0;
                            o_acc_next = h2_ok;
                            o_st_next = crc8fpf_pkg::STAT_OK;
                            o_cmd_next = '0;
                            o_sz_next = '0;
                            o_db_next = '0;
                            o_dv_next = 1'b0;
                            o_last_next = 1'b1;
                            if (h2_ok)
                            begin
                                s = h2;
                                if (st_eff[s] == crc8fpf_pkg::ENTRY_EMPTY)
                                begin
                                    start_next[s] = time_reg;
                                    f = '0;
                                    crc_next[s] = crc8fpf_pkg::crc_shift(crc8fpf_pkg::CRC_INIT)
                                                  ^ req.rx_byte;
                                end
                                else
                                begin
                                    f = fill_reg[s];
                                    crc_next[s] = crc8fpf_pkg::crc_shift(crc_reg[s])
                                                  ^ req.rx_byte;
                                end
                                ram_we = 1'b1;
                                ram_waddr = AW'(s) * AW'(CAP) + AW'(f);
                                if (f == FW'(0)) byte0_next[s] = req.rx_byte;
                                if (f == FW'(1)) size_next[s] = req.rx_byte;
                                if (f == FW'(2)) cmd_next[s] = req.rx_byte;
                                f = f + FW'(1);
                                fill_next[s] = f;
                                szb = (f == FW'(2)) ? req.rx_byte : size_reg[s];
                                if (f >= FW'(CAP))
                                begin
                                    status_next[s] = crc8fpf_pkg::ENTRY_FULL;
                                end
                                else if (f >= FW'(2) && {1'b0, f} >= {1'b0, szb[6:0]} + 8'd4)
                                begin
                                    status_next[s] = crc8fpf_pkg::ENTRY_FULL;
                                end
                                else
                                begin
                                    status_next[s] = crc8fpf_pkg::ENTRY_FILLING;
                                end
                            end
                        end
                        crc8fpf_pkg::KIND_POP:
                        begin
                            nx = next_slot(rslot_reg);
                            ov_next = 1'b1;
                            o_rk_next = 1'b1;
                            o_acc_next = 1'b0;
                            o_db_next = '0;
                            o_dv_next = 1'b0;
                            o_last_next = 1'b1;
                            if (status_reg[rslot_reg] == crc8fpf_pkg::ENTRY_FULL)
                            begin
                                s = rslot_reg; h1_ok = 1'b1;
                            end
                            else if (status_reg[nx] == crc8fpf_pkg::ENTRY_FULL)
                            begin
                                s = nx; h1_ok = 1'b1; rslot_next = nx;
                            end
                            if (!h1_ok)
                            begin
                                o_st_next = crc8fpf_pkg::STAT_EMPTY;
                                o_cmd_next = '0;
                                o_sz_next = '0;
                            end
                            else
                            begin
                                status_next[s] = crc8fpf_pkg::ENTRY_EMPTY;
                                f = fill_reg[s];
                                szb = (f >= FW'(2)) ? size_reg[s] : 8'd0;
                                cl = (f >= FW'(3)) ? cmd_reg[s] : 8'd0;
                                sz = szb[6:0];
                                if (sz > crc8fpf_pkg::MAX_PAYLOAD)
                                    st = crc8fpf_pkg::STAT_SIZE;
                                else if (byte0_reg[s] != crc8fpf_pkg::START_MARK)
                                    st = crc8fpf_pkg::STAT_START;
                                else if ({1'b0, f} != {1'b0, sz} + 8'd4)
                                    st = crc8fpf_pkg::STAT_LENGTH;
                                else if (crc8fpf_pkg::crc_shift(crc_reg[s]) != 8'd0)
                                    st = crc8fpf_pkg::STAT_CRC;
                                else
                                    st = crc8fpf_pkg::STAT_OK;
                                o_st_next = st;
                                o_cmd_next = {szb[7], cl};
                                o_sz_next = sz;
                                if (st == crc8fpf_pkg::STAT_OK && sz != 7'd0)
                                begin
                                    // hold the report and stream the payload
                                    ov_next = 1'b0;
                                    base_next = AW'(s) * AW'(CAP) + AW'(3);
                                    idx_next = '0;
                                    ssize_next = sz;
                                    scmd_next = {szb[7], cl};
                                    state_next = S_READ;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ram_re = 1'b1;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    o_rk_next = 1'b1;
                    o_acc_next = 1'b0;
                    o_st_next = crc8fpf_pkg::STAT_OK;
                    o_cmd_next = scmd_reg;
                    o_sz_next = ssize_reg;
                    o_db_next = ram_rdata;
                    o_dv_next = 1'b1;
                    o_last_next = (idx_reg + 7'd1 == ssize_reg);
                    if (idx_reg + 7'd1 == ssize_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 7'd1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    crc8fpf_ram #(
        .WIDTH(8),
        .DEPTH(crc8fpf_pkg::STORE_DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(req.rx_byte),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < RING; i++)
            begin
                status_reg[i] <= crc8fpf_pkg::ENTRY_EMPTY;
                fill_reg[i] <= '0;
                crc_reg[i] <= crc8fpf_pkg::CRC_INIT;
            end
            wslot_reg <= '0;
            rslot_reg <= '0;
            time_reg <= '0;
            timeout_reg <= crc8fpf_pkg::TIMEOUT_RESET;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            status_reg <= status_next;
            fill_reg <= fill_next;
            crc_reg <= crc_next;
            wslot_reg <= wslot_next;
            rslot_reg <= rslot_next;
            time_reg <= time_next;
            ov_reg <= ov_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        byte0_reg <= byte0_next;
        size_reg <= size_next;
        cmd_reg <= cmd_next;
        base_reg <= base_next;
        idx_reg <= idx_next;
        ssize_reg <= ssize_next;
        scmd_reg <= scmd_next;
        o_rk_reg <= o_rk_next;
        o_acc_reg <= o_acc_next;
        o_st_reg <= o_st_next;
        o_cmd_reg <= o_cmd_next;
        o_sz_reg <= o_sz_next;
        o_db_reg <= o_db_next;
        o_dv_reg <= o_dv_next;
        o_last_reg <= o_last_next;
    end

    assign rsp.valid        = ov_reg;
    assign rsp.reply_kind   = o_rk_reg;
    assign rsp.accepted     = o_acc_reg;
    assign rsp.status       = o_st_reg;
    assign rsp.command      = o_cmd_reg;
    assign rsp.payload_size = o_sz_reg;
    assign rsp.data_byte    = o_db_reg;
    assign rsp.data_valid   = o_dv_reg;
    assign rsp.last         = o_last_reg;

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("store written while streaming");
    a_send_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEND |-> $past(state_reg) == S_READ || $past(state_reg) == S_SEND)
        else $error("send without a store read");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND && out_free && idx_reg + 7'd1 == ssize_reg)
        |=> state_reg == S_IDLE && rsp.valid && rsp.last)
        else $error("stream did not end on last byte");
    a_no_req_stream: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !req.ready)
        else $error("request taken during stream");
endmodule
`default_nettype wire

/* test/tb_crc8_framed_packet_fifo.sv */
// Testbench for the framed packet receiver: random byte, tick and pop requests checked on the fly.
`default_nettype none
module tb_crc8_framed_packet_fifo;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int CORRUPT_NONE  = 0;
    localparam int CORRUPT_CRC   = 1;
    localparam int CORRUPT_START = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } request_t;

    typedef struct packed {
        logic       reply_kind;
        logic       accepted;
        logic [2:0] status;
        logic [8:0] command;
        logic [6:0] payload_size;
        logic [7:0] data_byte;
        logic       data_valid;
        logic       last;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    crc8fpf_req_if req_ch ();
    crc8fpf_rsp_if rsp_ch ();

    crc8_framed_packet_fifo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source)
    );

    // Predictor state for the ring of frame buffers
    logic [1:0]  buf_state [crc8fpf_pkg::RING_ENTRIES];
    logic [7:0]  buf_bytes [crc8fpf_pkg::STORE_DEPTH];
    logic [6:0]  buf_fill  [crc8fpf_pkg::RING_ENTRIES];
    logic [31:0] buf_since [crc8fpf_pkg::RING_ENTRIES];
    logic [7:0]  buf_crc   [crc8fpf_pkg::RING_ENTRIES];
    int unsigned fill_ptr;
    int unsigned drain_ptr;
    logic [31:0] tick_count;
    logic [31:0] timeout_reg;

    request_t pending_reqs [$];
    report_t  expected_reports [$];
    int       n_items;
    int       n_sent;
    int       n_checked;
    int       n_frames_ok;
    int       n_errors;
    int       n_drops;
    int       cycle_count;
    int       req_gap;
    int       rsp_gap;
    int       calm_left;
    bit       hold_requests;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [7:0] crc_times_x8(input logic [7:0] v);
        logic [8:0] acc;
        acc = {1'b0, v};
        for (int k = 0; k < 8; k++)
        begin
            acc = acc << 1;
            if (acc[8])
                acc = acc ^ 9'h1CF;
        end
        return acc[7:0];
    endfunction

    function automatic int unsigned slot_after(input int unsigned s);
        return (s + 1 >= crc8fpf_pkg::RING_ENTRIES) ? 0 : s + 1;
    endfunction

    function automatic int fill_target();
        int unsigned nx;
        if (buf_state[fill_ptr] != crc8fpf_pkg::ENTRY_FULL)
            return fill_ptr;
        nx = slot_after(fill_ptr);
        if (buf_state[nx] == crc8fpf_pkg::ENTRY_EMPTY)
        begin
            fill_ptr = nx;
            return nx;
        end
        return -1;
    endfunction

    function automatic int drain_target();
        int unsigned nx;
        if (buf_state[drain_ptr] == crc8fpf_pkg::ENTRY_FULL)
            return drain_ptr;
        nx = slot_after(drain_ptr);
        if (buf_state[nx] == crc8fpf_pkg::ENTRY_FULL)
        begin
            drain_ptr = nx;
            return nx;
        end
        return -1;
    endfunction

    function automatic void add_report(input logic rk, input logic acc, input logic [2:0] st,
                                       input logic [8:0] cmd, input logic [6:0] sz,
                                       input logic [7:0] db, input logic dv, input logic lst);
        report_t r;
        r = '{rk, acc, st, cmd, sz, db, dv, lst};
        expected_reports.push_back(r);
    endfunction

    function automatic void predict_request(input logic [1:0] kind, input logic [7:0] b);
        int s;
        int base;
        int f;
        logic [7:0] szb;
        logic [7:0] cl;
        logic [6:0] sz;
        logic [8:0] cmd;
        logic [2:0] st;
        if (kind == crc8fpf_pkg::KIND_TICK)
        begin
            tick_count = tick_count + 1;
        end
        else if (kind == crc8fpf_pkg::KIND_BYTE)
        begin
            s = fill_target();
            if (s >= 0 && buf_state[s] == crc8fpf_pkg::ENTRY_FILLING &&
                (tick_count - buf_since[s]) > timeout_reg)
                buf_state[s] = crc8fpf_pkg::ENTRY_FULL;
            s = fill_target();
            if (s < 0)
            begin
                n_drops++;
                add_report(1'b0, 1'b0, crc8fpf_pkg::STAT_OK, '0, '0, '0, 1'b0, 1'b1);
            end
            else
            begin
                if (buf_state[s] == crc8fpf_pkg::ENTRY_EMPTY)
                begin
                    buf_state[s] = crc8fpf_pkg::ENTRY_FILLING;
                    buf_since[s] = tick_count;
                    buf_fill[s]  = '0;
                    buf_crc[s]   = crc8fpf_pkg::CRC_INIT;
                end
                base = s * crc8fpf_pkg::FRAME_CAPACITY;
                f = buf_fill[s];
                if (f < crc8fpf_pkg::FRAME_CAPACITY)
                begin
                    buf_bytes[base + f] = b;
                    f++;
                    buf_fill[s] = f[6:0];
                    buf_crc[s]  = crc_times_x8(buf_crc[s]) ^ b;
                end
                if (f >= crc8fpf_pkg::FRAME_CAPACITY)
                    buf_state[s] = crc8fpf_pkg::ENTRY_FULL;
                else if (f >= 2 && f >= int'(buf_bytes[base + 1][6:0]) + 4)
                    buf_state[s] = crc8fpf_pkg::ENTRY_FULL;
                add_report(1'b0, 1'b1, crc8fpf_pkg::STAT_OK, '0, '0, '0, 1'b0, 1'b1);
            end
        end
        else if (kind == crc8fpf_pkg::KIND_POP)
        begin
            s = drain_target();
            if (s < 0)
            begin
                add_report(1'b1, 1'b0, crc8fpf_pkg::STAT_EMPTY, '0, '0, '0, 1'b0, 1'b1);
            end
            else
            begin
                buf_state[s] = crc8fpf_pkg::ENTRY_EMPTY;
                base = s * crc8fpf_pkg::FRAME_CAPACITY;
                f   = buf_fill[s];
                szb = (f >= 2) ? buf_bytes[base + 1] : 8'h00;
                cl  = (f >= 3) ? buf_bytes[base + 2] : 8'h00;
                sz  = szb[6:0];
                cmd = {szb[7], cl};
                if (sz > crc8fpf_pkg::MAX_PAYLOAD)
                    st = crc8fpf_pkg::STAT_SIZE;
                else if (buf_bytes[base] != crc8fpf_pkg::START_MARK)
                    st = crc8fpf_pkg::STAT_START;
                else if (f != int'(sz) + 4)
                    st = crc8fpf_pkg::STAT_LENGTH;
                else if (crc_times_x8(buf_crc[s]) != 8'h00)
                    st = crc8fpf_pkg::STAT_CRC;
                else
                    st = crc8fpf_pkg::STAT_OK;
                if (st == crc8fpf_pkg::STAT_OK)
                    n_frames_ok++;
                if (st != crc8fpf_pkg::STAT_OK || sz == 0)
                    add_report(1'b1, 1'b0, st, cmd, sz, '0, 1'b0, 1'b1);
                else
                    for (int i = 0; i < sz; i++)
                        add_report(1'b1, 1'b0, crc8fpf_pkg::STAT_OK, cmd, sz,
                                   buf_bytes[base + 3 + i], 1'b1, (i + 1 == sz));
            end
        end
    endfunction

    // Mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm_left = $urandom_range(20, 60);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Request driver: advance on acceptance, predict what the accepted request causes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_ch.valid)
                begin
                    predict_request(req_ch.kind, req_ch.rx_byte);
                    n_sent++;
                end
                if (req_gap > 0)
                begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (!hold_requests && pending_reqs.size() > 0)
                begin
                    request_t it;
                    it = pending_reqs.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.kind    <= it.kind;
                    req_ch.rx_byte <= it.rx_byte;
                    req_gap = pick_gap();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                report_t got;
                report_t want;
                got = '{rsp_ch.reply_kind, rsp_ch.accepted, rsp_ch.status, rsp_ch.command,
                        rsp_ch.payload_size, rsp_ch.data_byte, rsp_ch.data_valid, rsp_ch.last};
                if (expected_reports.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected response %p", $realtime, got);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    n_checked++;
                    if (got !== want)
                    begin
                        n_errors++;
                        $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                    end
                end
            end
            if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                rsp_gap = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding", $realtime,
                     expected_reports.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_req(input logic [1:0] kind, input logic [7:0] b);
        request_t it;
        it = '{kind, b};
        pending_reqs.push_back(it);
        n_items++;
    endtask

    // Send one frame, intact or with a bad crc or a bad start byte
    task automatic push_frame(input int sz, input logic hi, input logic [7:0] cl, input int corrupt);
        logic [7:0] bytes [$];
        logic [7:0] c;
        bytes.push_back(corrupt == CORRUPT_START ? 8'($urandom_range(0, 255) & 8'hF0)
                                                 : crc8fpf_pkg::START_MARK);
        bytes.push_back({hi, 7'(sz)});
        bytes.push_back(cl);
        for (int i = 0; i < sz; i++)
            bytes.push_back(8'($urandom));
        c = crc8fpf_pkg::CRC_INIT;
        foreach (bytes[i])
            c = crc_times_x8(c) ^ bytes[i];
        c = crc_times_x8(c);
        if (corrupt == CORRUPT_CRC)
            c = c ^ 8'($urandom_range(1, 255));
        bytes.push_back(c);
        foreach (bytes[i])
            push_req(crc8fpf_pkg::KIND_BYTE, bytes[i]);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req_ch.valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] v);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        timeout_reg = v;
    endtask

    task automatic random_phase(input int count);
        int goal;
        int r;
        int sz;
        goal = n_items + count;
        while (n_items < goal)
        begin
            r = $urandom_range(0, 99);
            sz = ($urandom_range(0, 19) == 0) ? 64 : $urandom_range(0, 8);
            if (r < 50)
            begin
                push_frame(sz, 1'($urandom), 8'($urandom), CORRUPT_NONE);
                if ($urandom_range(0, 9) < 7)
                    push_req(crc8fpf_pkg::KIND_POP, 8'($urandom));
            end
            else if (r < 58)
            begin
                push_frame(sz, 1'($urandom), 8'($urandom), CORRUPT_CRC);
                push_req(crc8fpf_pkg::KIND_POP, 8'($urandom));
            end
            else if (r < 63)
            begin
                push_frame(sz, 1'($urandom), 8'($urandom), CORRUPT_START);
                push_req(crc8fpf_pkg::KIND_POP, 8'($urandom));
            end
            else if (r < 66)
            begin
                // oversize field: the buffer closes at capacity
                push_req(crc8fpf_pkg::KIND_BYTE, crc8fpf_pkg::START_MARK);
                push_req(crc8fpf_pkg::KIND_BYTE, {1'($urandom), 7'($urandom_range(65, 127))});
                for (int i = 2; i < crc8fpf_pkg::FRAME_CAPACITY; i++)
                    push_req(crc8fpf_pkg::KIND_BYTE, 8'($urandom));
                push_req(crc8fpf_pkg::KIND_POP, 8'($urandom));
            end
            else if (r < 74)
            begin
                // short frame followed by ticks, for the timeout to close on a later byte
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    push_req(crc8fpf_pkg::KIND_BYTE,
                             (i == 3) ? crc8fpf_pkg::START_MARK : 8'($urandom));
                for (int i = $urandom_range(0, 5); i > 0; i--)
                    push_req(crc8fpf_pkg::KIND_TICK, 8'($urandom));
                push_req(crc8fpf_pkg::KIND_POP, 8'($urandom));
            end
            else if (r < 80)
            begin
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    push_req(crc8fpf_pkg::KIND_BYTE, 8'($urandom));
            end
            else if (r < 90)
            begin
                push_req(crc8fpf_pkg::KIND_POP, 8'($urandom));
            end
            else
            begin
                push_req($urandom_range(0, 1) ? crc8fpf_pkg::KIND_TICK : KIND_NONE,
                         8'($urandom));
            end
        end
    endtask

    initial
    begin
        n_items = 0; n_sent = 0; n_checked = 0; n_errors = 0; n_drops = 0; n_frames_ok = 0;
        cycle_count = 0; req_gap = 0; rsp_gap = 0; calm_left = 0; hold_requests = 1'b0;
        foreach (buf_state[i])
        begin
            buf_state[i] = crc8fpf_pkg::ENTRY_EMPTY;
            buf_fill[i]  = '0;
            buf_since[i] = '0;
            buf_crc[i]   = crc8fpf_pkg::CRC_INIT;
        end
        foreach (buf_bytes[i])
            buf_bytes[i] = '0;
        fill_ptr = 0; drain_ptr = 0; tick_count = '0;
        timeout_reg = crc8fpf_pkg::TIMEOUT_RESET;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_NONE;
        req_ch.rx_byte = '0;
        rsp_ch.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pop, empty and one-byte payloads, crc and start errors, idle kinds
        push_req(crc8fpf_pkg::KIND_POP, 8'hFF);
        push_frame(0, 1'b0, 8'h00, CORRUPT_NONE);
        push_req(crc8fpf_pkg::KIND_POP, 8'h00);
        push_frame(1, 1'b1, 8'hFF, CORRUPT_NONE);
        push_req(crc8fpf_pkg::KIND_POP, 8'h00);
        push_frame(0, 1'b1, 8'hA5, CORRUPT_CRC);
        push_req(crc8fpf_pkg::KIND_POP, 8'h00);
        push_frame(0, 1'b0, 8'h3C, CORRUPT_START);
        push_req(crc8fpf_pkg::KIND_POP, 8'h00);
        push_req(KIND_NONE, 8'hFF);
        push_req(crc8fpf_pkg::KIND_TICK, 8'h00);
        push_req(crc8fpf_pkg::KIND_POP, 8'h00);

        write_timeout(32'hFFFF_FFFF);
        random_phase(50);
        write_timeout(32'd3);
        random_phase(100);
        // Pressure: hold the pending requests until every response is back
        hold_requests = 1'b1;
        while (req_ch.valid || expected_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        hold_requests = 1'b0;
        random_phase(35);
        write_timeout(32'd0);
        random_phase(80);
        write_timeout(crc8fpf_pkg::TIMEOUT_RESET);
        random_phase(70);
        wait_idle();

        $display("covered %0d requests, %0d responses, %0d good frames, %0d dropped bytes",
                 n_sent, n_checked, n_frames_ok, n_drops);
        $display("timeouts of 0, 3, 10000 and all ones; ring overflow, bad frames, empty pops");
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire
